// ----- sv/sld_pkg.sv -----
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types and constants for the sync-word, length-prefixed deframer.
// ----------------------------------------------------------------------------
package sld_pkg;

    // Sync word as it sits in the window, first received byte in the low byte
    localparam logic [31:0] SYNC_WORD  = 32'h414D5553;
    // Index of the final byte of a four-byte header field
    localparam logic [1:0]  FIELD_LAST = 2'd3;
    // Largest flag byte that is taken as a valid compress flag
    localparam logic [7:0]  FLAG_MAX   = 8'd1;

    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_FLAG = 5'b00010,
        PH_ID   = 5'b00100,
        PH_LEN  = 5'b01000,
        PH_DATA = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [31:0] message_id;
        logic        compressed;
        logic        empty_message;
        logic        last;
    } result_t;

    // Transaction handed from the parser to the output register
    typedef struct packed {
        logic    valid;
        result_t data;
    } result_slot_t;

endpackage

// ----- sv/sync_length_frame_deframer.sv -----
// Path: an accepted byte sits in the input register, passes the combinational
//   parser and is captured by the output register, which drives out_valid.
// Throughput: one byte per cycle unless stalled; one-pass parser state update.
// Backpressure: out_stall holds the output register and, once the input
//   register is also full, raises in_stall.
// Reset: asynchronous, active low; the parser returns to sync hunting.
// ----------------------------------------------------------------------------
// sync_length_frame_deframer
// Sync-word, length-prefixed deframer, one received byte per unstalled cycle.
// ----------------------------------------------------------------------------
module sync_length_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  payload_byte,
    output logic [31:0] message_id,
    output logic        compressed,
    output logic        empty_message,
    output logic        last
);
    import sld_pkg::*;

    logic         out_free;
    logic         advance;
    logic [7:0]   item_byte;
    result_slot_t res;
    result_t      out_data;

    sld_in_stage u_in_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_free  (out_free),
        .advance   (advance),
        .item_byte (item_byte)
    );

    sld_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item_byte (item_byte),
        .res       (res)
    );

    sld_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign payload_byte  = out_data.payload_byte;
    assign message_id    = out_data.message_id;
    assign compressed    = out_data.compressed;
    assign empty_message = out_data.empty_message;
    assign last          = out_data.last;

endmodule

// ----- sv/sld_in_stage.sv -----
// ----------------------------------------------------------------------------
// sld_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module sld_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       out_free,
    output logic       advance,
    output logic [7:0] item_byte
);
    import sld_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       accept;

    assign advance  = valid_reg && out_free;
    assign in_stall = valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= in_byte;
        end
    end

    assign item_byte = byte_reg;

endmodule

// ----- sv/sld_parser.sv -----
// ----------------------------------------------------------------------------
// sld_parser
// Header parser: sync hunt, flag, id and length fields, payload byte count.
// ----------------------------------------------------------------------------
module sld_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic [7:0]            item_byte,
    output sld_pkg::result_slot_t res
);
    import sld_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [31:0] window_reg;
    logic [31:0] window_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic [31:0] id_reg;
    logic [31:0] id_next;
    logic [31:0] len_reg;
    logic [31:0] len_next;
    logic [31:0] left_reg;
    logic [31:0] left_next;
    logic        comp_reg;
    logic        comp_next;

    logic [31:0] window_shift;
    logic        window_hit;
    logic [31:0] byte_placed;
    logic [31:0] len_word;
    logic [31:0] left_dec;

    assign window_shift = {item_byte, window_reg[31:8]};
    assign window_hit   = (window_shift == SYNC_WORD);
    assign byte_placed  = {24'd0, item_byte} << {count_reg, 3'b000};
    assign len_word     = len_reg | byte_placed;
    assign left_dec     = left_reg - 32'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        window_next = window_reg;
        count_next  = count_reg;
        id_next     = id_reg;
        len_next    = len_reg;
        left_next   = left_reg;
        comp_next   = comp_reg;

        res.valid              = 1'b0;
        res.data.payload_byte  = item_byte;
        res.data.message_id    = id_reg;
        res.data.compressed    = comp_reg;
        res.data.empty_message = 1'b0;
        res.data.last          = 1'b0;

        if (advance)
        begin
            case (phase_reg)
                PH_FLAG:
                begin
                    if (item_byte > FLAG_MAX)
                    begin
                        // keep the bad flag byte in the window and hunt on
                        window_next = window_shift;
                        phase_next  = window_hit ? PH_FLAG : PH_HUNT;
                    end
                    else
                    begin
                        comp_next   = item_byte[0];
                        window_next = '0;
                        id_next     = '0;
                        count_next  = '0;
                        phase_next  = PH_ID;
                    end
                end
                PH_ID:
                begin
                    id_next = id_reg | byte_placed;
                    if (count_reg == FIELD_LAST)
                    begin
                        count_next = '0;
                        len_next   = '0;
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        count_next = count_reg + 2'd1;
                    end
                end
                PH_LEN:
                begin
                    len_next = len_word;
                    if (count_reg != FIELD_LAST)
                    begin
                        count_next = count_reg + 2'd1;
                    end
                    else
                    begin
                        count_next = '0;
                        if (len_word == '0)
                        begin
                            // zero-length message: one empty transaction
                            res.valid              = 1'b1;
                            res.data.payload_byte  = '0;
                            res.data.empty_message = 1'b1;
                            res.data.last          = 1'b1;
                            phase_next             = PH_HUNT;
                        end
                        else
                        begin
                            left_next  = len_word;
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    left_next     = left_dec;
                    res.valid     = 1'b1;
                    res.data.last = (left_dec == '0);
                    if (left_dec == '0)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                default:
                begin
                    window_next = window_shift;
                    phase_next  = window_hit ? PH_FLAG : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            window_reg <= '0;
            count_reg  <= '0;
            id_reg     <= '0;
            len_reg    <= '0;
            left_reg   <= '0;
            comp_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            count_reg  <= count_next;
            id_reg     <= id_next;
            len_reg    <= len_next;
            left_reg   <= left_next;
            comp_reg   <= comp_next;
        end
    end

endmodule

// ----- sv/sld_out_stage.sv -----
// ----------------------------------------------------------------------------
// sld_out_stage
// Output register: holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module sld_out_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sld_pkg::result_slot_t res,
    output logic                  out_free,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sld_pkg::result_t      out_data
);
    import sld_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign out_free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_free)
        begin
            valid_next = res.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res.valid)
        begin
            data_reg <= res.data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- sv/sld_checker.sv -----
// ----------------------------------------------------------------------------
// sld_checker
// Port-level checks on the deframer's result stream.
// ----------------------------------------------------------------------------
module sld_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  payload_byte,
    input  logic [31:0] message_id,
    input  logic        compressed,
    input  logic        empty_message,
    input  logic        last
);
    import sld_pkg::*;

    logic        in_msg_reg;
    logic        in_msg_next;
    logic [31:0] id_reg;
    logic        comp_reg;
    logic        out_take;

    assign out_take = out_valid && !out_stall;

    always_comb
    begin
        in_msg_next = in_msg_reg;
        if (out_take)
        begin
            in_msg_next = !last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_msg_reg <= 1'b0;
        end
        else
        begin
            in_msg_reg <= in_msg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            id_reg   <= message_id;
            comp_reg <= compressed;
        end
    end

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(payload_byte)
            && $stable(message_id) && $stable(last) && $stable(empty_message))
        else $error("stalled result transaction changed");

    // an empty message is a single closing transaction with a zero byte
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_message |-> last && (payload_byte == 8'd0))
        else $error("empty message result not marked last or byte nonzero");

    // within a message, id and compress flag stay fixed and no empty mark shows
    a_msg_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_msg_reg |-> (message_id == id_reg)
            && (compressed == comp_reg) && !empty_message)
        else $error("message fields changed inside a message");

endmodule

bind sync_length_frame_deframer sld_checker u_sld_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_byte  (payload_byte),
    .message_id    (message_id),
    .compressed    (compressed),
    .empty_message (empty_message),
    .last          (last)
);

// ----- tb/sv/tb_sync_length_frame_deframer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sync_length_frame_deframer
// Drives a received byte stream into the deframer and checks every payload
// transaction against an in-bench deframer model: a short directed list of
// frames first, then random frames with noise, broken syncs and embedded
// sync words, under several sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------
module tb_sync_length_frame_deframer;

    import sld_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_BYTES  = 325;
    localparam int TAIL_CYCLES  = 20;
    localparam int IDLE_PCT  [4] = '{0, 81, 0, 31};
    localparam int STALL_PCT [4] = '{0, 0, 81, 31};

    typedef struct packed {
        logic [7:0] stim;
        bit         typed;
        result_t    want;
    } dir_row_t;

    localparam int DIR_ROWS = 31;
    localparam dir_row_t DIR_LIST [DIR_ROWS] = '{
        // sync, then a bad flag that also starts the next sync
        '{8'h53, 1'b0, '0}, '{8'h55, 1'b0, '0}, '{8'h4D, 1'b0, '0}, '{8'h41, 1'b0, '0},
        '{8'h53, 1'b0, '0}, '{8'h55, 1'b0, '0}, '{8'h4D, 1'b0, '0}, '{8'h41, 1'b0, '0},
        // compressed, id all ones, zero length
        '{8'h01, 1'b0, '0},
        '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{8'h00, 32'hFFFFFFFF, 1'b1, 1'b1, 1'b1}},
        // fresh sync, plain frame with one payload byte
        '{8'h53, 1'b0, '0}, '{8'h55, 1'b0, '0}, '{8'h4D, 1'b0, '0}, '{8'h41, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h78, 1'b0, '0}, '{8'h56, 1'b0, '0}, '{8'h34, 1'b0, '0}, '{8'h12, 1'b0, '0},
        '{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b1, '{8'hFF, 32'h12345678, 1'b0, 1'b0, 1'b1}}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  payload_byte;
    logic [31:0] message_id;
    logic        compressed;
    logic        empty_message;
    logic        last;

    // deframer model state
    logic [31:0] sync_win;
    phase_t      ph;
    logic [1:0]  fcount;
    logic [31:0] cur_id;
    logic [31:0] cur_len;
    logic [31:0] remaining;
    logic        cur_comp;

    result_t     pending_results [$];
    int          error_count;
    int          quiet_cycles;
    int          bytes_sent;
    int          idle_pct;
    int          stall_pct;

    sync_length_frame_deframer u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .payload_byte  (payload_byte),
        .message_id    (message_id),
        .compressed    (compressed),
        .empty_message (empty_message),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic void shift_window(input logic [7:0] b);
        sync_win = {b, sync_win[31:8]};
        ph = (sync_win == SYNC_WORD) ? PH_FLAG : PH_HUNT;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, output bit produced,
                                         output result_t res);
        produced = 1'b0;
        res = '0;
        res.message_id = cur_id;
        res.compressed = cur_comp;
        case (ph)
            PH_FLAG:
            begin
                if (b > FLAG_MAX)
                begin
                    shift_window(b);
                end
                else
                begin
                    cur_comp = b[0];
                    sync_win = '0;
                    cur_id   = '0;
                    fcount   = '0;
                    ph       = PH_ID;
                end
            end
            PH_ID:
            begin
                cur_id |= {24'h0, b} << {fcount, 3'b000};
                if (fcount == FIELD_LAST)
                begin
                    fcount  = '0;
                    cur_len = '0;
                    ph      = PH_LEN;
                end
                else
                begin
                    fcount = fcount + 2'd1;
                end
            end
            PH_LEN:
            begin
                cur_len |= {24'h0, b} << {fcount, 3'b000};
                if (fcount != FIELD_LAST)
                begin
                    fcount = fcount + 2'd1;
                end
                else
                begin
                    fcount = '0;
                    if (cur_len == 32'd0)
                    begin
                        produced = 1'b1;
                        res.empty_message = 1'b1;
                        res.last = 1'b1;
                        ph = PH_HUNT;
                    end
                    else
                    begin
                        remaining = cur_len;
                        ph = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                remaining = remaining - 32'd1;
                produced = 1'b1;
                res.payload_byte = b;
                res.last = (remaining == 32'd0);
                if (remaining == 32'd0)
                    ph = PH_HUNT;
            end
            default:
            begin
                shift_window(b);
            end
        endcase
    endfunction

    // Present one byte, hold it until accepted, then record what it should produce
    task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
        bit      produced;
        result_t res;
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
        deframe_byte(b, produced, res);
        if (typed)
            pending_results.push_back(want);
        else if (produced)
            pending_results.push_back(res);
    endtask

    // Drop valid and hold off until every pending transaction has come out
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_frame();
        int          r;
        int          n;
        int          embed;
        logic [31:0] len;
        logic [7:0]  b;
        r = $urandom_range(0, 99);
        if (r < 20)
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
            begin
                // stop if noise happened to complete a sync word
                if (ph != PH_HUNT)
                    break;
                send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            end
        end
        else if (r < 30)
        begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                send_byte(SYNC_WORD[8*i +: 8], 1'b0, '0);
        end
        for (int i = 0; i < 4; i++)
            send_byte(SYNC_WORD[8*i +: 8], 1'b0, '0);
        if ($urandom_range(0, 9) == 0)
        begin
            send_byte(8'($urandom_range(2, 255)), 1'b0, '0);
            return;
        end
        send_byte(8'($urandom_range(0, 1)), 1'b0, '0);
        for (int i = 0; i < 4; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        r = $urandom_range(0, 99);
        if (r < 12)
            len = 32'd0;
        else if (r < 95)
            len = 32'($urandom_range(1, 8));
        else if (r < 98)
            len = 32'($urandom_range(9, 40));
        else
            len = 32'($urandom_range(256, 300));
        for (int i = 0; i < 4; i++)
            send_byte(len[8*i +: 8], 1'b0, '0);
        embed = -1;
        if (len >= 32'd4 && $urandom_range(0, 5) == 0)
            embed = $urandom_range(0, int'(len) - 4);
        for (int i = 0; i < int'(len); i++)
        begin
            if (embed >= 0 && i >= embed && i < embed + 4)
                b = SYNC_WORD[8*(i - embed) +: 8];
            else
                b = 8'($urandom_range(0, 255));
            send_byte(b, 1'b0, '0);
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected transaction: payload_byte 0x%0h message_id 0x%0h",
                       payload_byte, message_id);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("payload_byte", {24'h0, want.payload_byte}, {24'h0, payload_byte});
                check_field("message_id", want.message_id, message_id);
                check_field("compressed", {31'h0, want.compressed}, {31'h0, compressed});
                check_field("empty_message", {31'h0, want.empty_message},
                            {31'h0, empty_message});
                check_field("last", {31'h0, want.last}, {31'h0, last});
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_sync_length_frame_deframer failed");
                $finish;
            end
        end
    end

    initial
    begin
        int start_count;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_byte      = 8'h00;
        bytes_sent   = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        sync_win     = '0;
        ph           = PH_HUNT;
        fcount       = '0;
        cur_id       = '0;
        cur_len      = '0;
        remaining    = '0;
        cur_comp     = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_byte(DIR_LIST[i].stim, DIR_LIST[i].typed, DIR_LIST[i].want);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = IDLE_PCT[p];
            stall_pct = STALL_PCT[p];
            start_count = bytes_sent;
            while (bytes_sent - start_count < PHASE_BYTES)
                send_random_frame();
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_sync_length_frame_deframer passed");
        else
            $display("tb_sync_length_frame_deframer failed");
        $finish;
    end

endmodule
